[rtl/ttf_pkg.sv]
// ----------------------------------------------------------------------------
// ttf_pkg: shared definitions for the triangle tangent frame block
// Port widths, register codes and reset values, pipeline depths and the
// records that travel alongside the data through the deep pipeline.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int POS_W     = 48;
  localparam int TEX_W     = 32;
  localparam int VEC_W     = 60;
  localparam int NRM_W     = 48;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Quotient bits of the tangent and normal dividers, root bits of the sqrt.
  localparam int T_QW    = 20;
  localparam int N_QW    = 15;
  localparam int SQRT_RW = 32;

  // The normal path runs two stages, the square root, one prep stage and its
  // divider after the point where the tangent divider starts.
  localparam int TAN_DLY = 3 + SQRT_RW + N_QW - T_QW;

  localparam logic [CFG_W-1:0] THR_RST    = 16'd268;
  localparam logic             NRM_EN_RST = 1'b1;

  localparam logic [T_QW-1:0] T_MAX = 20'h7FFFF;
  localparam logic [T_QW-1:0] T_MIN = 20'h80000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH = 1'b0,
    CFG_NRM_EN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [T_QW-1:0] quo;
  } tan_res_t;

  typedef struct packed {
    logic               vld;
    logic               deg;
    tan_res_t [5:0]     res;
  } tan_dly_t;

  typedef struct packed {
    logic             nen;
    logic             az;
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
  } nrm_side_t;

endpackage

[rtl/ttf_div.sv]
// ----------------------------------------------------------------------------
// ttf_div: pipelined restoring divider
// One quotient bit per stage, most significant first. The numerator must be
// below den << QW. Side bits ride along with each word unchanged.
// ----------------------------------------------------------------------------
module ttf_div #(
  parameter int NW = 50,
  parameter int DW = 36,
  parameter int QW = 20,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_r  [QW];
  logic [W-1:0]  rem_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stg
    logic          vld_i;
    logic [W-1:0]  rem_i;
    logic [QW-1:0] quo_i;
    logic [DW-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [W-1:0]  dsh;
    logic          ge;
    logic [W-1:0]  rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = W'(in_num);
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign quo_i  = quo_r[i-1];
      assign den_i  = den_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign dsh     = W'(den_i) << (QW - 1 - i);
    assign ge      = rem_i >= dsh;
    assign rem_nxt = ge ? rem_i - dsh : rem_i;
    assign quo_nxt = quo_i | (QW'(ge) << (QW - 1 - i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        quo_r[i]  <= quo_nxt;
        den_r[i]  <= den_i;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

[rtl/ttf_sqrt.sv]
// ----------------------------------------------------------------------------
// ttf_sqrt: pipelined integer square root
// Digit-by-digit floor square root, two radicand bits per stage. Side bits
// ride along with each word unchanged.
// ----------------------------------------------------------------------------
module ttf_sqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  localparam int XW  = 2 * RW;
  localparam int EW  = RW + 2;
  localparam int R2W = RW + 4;

  logic          vld_r  [RW];
  logic [XW-1:0] x_r    [RW];
  logic [EW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] side_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stg
    logic           vld_i;
    logic [XW-1:0]  x_i;
    logic [EW-1:0]  rem_i;
    logic [RW-1:0]  root_i;
    logic [SW-1:0]  side_i;
    logic [R2W-1:0] rem2;
    logic [R2W-1:0] trial;
    logic           ge;
    logic [EW-1:0]  rem_nxt;
    logic [RW-1:0]  root_nxt;

    if (i == 0) begin : g_first
      assign vld_i  = in_vld;
      assign x_i    = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[i-1];
      assign x_i    = x_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign rem2     = {rem_i, x_i[XW-1 -: 2]};
    assign trial    = R2W'({root_i, 2'b01});
    assign ge       = rem2 >= trial;
    assign rem_nxt  = ge ? EW'(rem2 - trial) : EW'(rem2);
    assign root_nxt = {root_i[RW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_i << 2;
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

[rtl/triangle_tangent_frame.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_frame: per-triangle tangent, bitangent and face normal
// Takes one triangle word (three Q8.8 positions, three Q2.14 texture
// coordinates) and returns one result word with tangent and bitangent in
// Q12.8, the unit face normal in Q1.14 and three status flags.
// ----------------------------------------------------------------------------
// Usage notes.
// The input and result channels each use valid and stall. A word moves at a
// rising clock edge where valid is high and stall is low.
// The block is a single pipeline of 56 register stages. A new triangle can
// enter every cycle while the result channel is not stalled; the pace is
// one word per cycle with no gaps.
// The depth is set by the normal path: the 32-stage square root of the
// squared normal length and the 15-stage divider that scales each component.
// The tangent path (20-stage divider) is padded by a delay line to match.
// When the receiver stalls while a result waits in the output register, the
// whole pipeline holds and in_stall is raised in the same cycle; nothing is
// dropped or repeated. Bubbles in the pipeline are not squeezed out.
// Reset (synchronous, active low) clears all valid bits, sets the determinant
// threshold to 268 and turns the face normal on. Configuration writes take
// effect at once; the user, not the block, keeps them to an empty pipeline.
// ----------------------------------------------------------------------------
module triangle_tangent_frame (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ttf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttf_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ttf_pkg::POS_W-1:0]      in_first_position,
  input  logic [ttf_pkg::POS_W-1:0]      in_second_position,
  input  logic [ttf_pkg::POS_W-1:0]      in_third_position,
  input  logic [ttf_pkg::TEX_W-1:0]      in_first_texcoord,
  input  logic [ttf_pkg::TEX_W-1:0]      in_second_texcoord,
  input  logic [ttf_pkg::TEX_W-1:0]      in_third_texcoord,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ttf_pkg::VEC_W-1:0]      out_tangent_vector,
  output logic [ttf_pkg::VEC_W-1:0]      out_bitangent_vector,
  output logic [ttf_pkg::NRM_W-1:0]      out_face_normal,
  output logic                           out_uv_degenerate,
  output logic                           out_area_zero,
  output logic                           out_saturated
);

  import ttf_pkg::*;

  // Cyclic neighbors used by the cross product.
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  // Tangent divider: numerator |n| * 2^15 + |D|, denominator 2 |D|.
  localparam int TN_W = 50;
  localparam int TD_W = 36;
  // Normal divider: numerator m * 2^15 + r, denominator 2 r.
  localparam int NN_W = 47;
  localparam int ND_W = 33;
  localparam int SIDE_W = $bits(nrm_side_t);

  // --------------------------------------------------------------------------
  // Flow control: every stage advances together unless a result is held.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] thr_r;
  logic             nrm_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RST;
      nrm_en_r <= NRM_EN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESH: thr_r    <= cfg_wdata;
        CFG_NRM_EN: nrm_en_r <= cfg_wdata[0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits of the stages in front of the dividers and the square root.
  // --------------------------------------------------------------------------
  logic vld_s1_r, vld_s2_r, vld_s3_r, vld_s4_r, vld_s5_r, vld_s6_r, vld_s7_r;
  logic vld_np_r;
  logic sq_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
      vld_s2_r <= 1'b0;
      vld_s3_r <= 1'b0;
      vld_s4_r <= 1'b0;
      vld_s5_r <= 1'b0;
      vld_s6_r <= 1'b0;
      vld_s7_r <= 1'b0;
      vld_np_r <= 1'b0;
    end else if (en) begin
      vld_s1_r <= in_valid;
      vld_s2_r <= vld_s1_r;
      vld_s3_r <= vld_s2_r;
      vld_s4_r <= vld_s3_r;
      vld_s5_r <= vld_s4_r;
      vld_s6_r <= vld_s5_r;
      vld_s7_r <= vld_s6_r;
      vld_np_r <= sq_vld;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: edges and texture deltas. The v flip to 1 - v cancels out of
  // the differences except for the sign, so dv = v0 - v1 on the raw values.
  // --------------------------------------------------------------------------
  logic signed [16:0] s1_e1_nxt [3], s1_e2_nxt [3], s1_e1_r [3], s1_e2_r [3];
  logic signed [16:0] s1_du1_nxt, s1_dv1_nxt, s1_du2_nxt, s1_dv2_nxt;
  logic signed [16:0] s1_du1_r, s1_dv1_r, s1_du2_r, s1_dv2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_e1_nxt[k] = {in_second_position[16*k+15], in_second_position[16*k +: 16]}
                   - {in_first_position[16*k+15], in_first_position[16*k +: 16]};
      s1_e2_nxt[k] = {in_third_position[16*k+15], in_third_position[16*k +: 16]}
                   - {in_first_position[16*k+15], in_first_position[16*k +: 16]};
    end
    s1_du1_nxt = {in_second_texcoord[15], in_second_texcoord[15:0]}
               - {in_first_texcoord[15], in_first_texcoord[15:0]};
    s1_du2_nxt = {in_third_texcoord[15], in_third_texcoord[15:0]}
               - {in_first_texcoord[15], in_first_texcoord[15:0]};
    s1_dv1_nxt = {in_first_texcoord[31], in_first_texcoord[31:16]}
               - {in_second_texcoord[31], in_second_texcoord[31:16]};
    s1_dv2_nxt = {in_first_texcoord[31], in_first_texcoord[31:16]}
               - {in_third_texcoord[31], in_third_texcoord[31:16]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e1_r  <= s1_e1_nxt;
      s1_e2_r  <= s1_e2_nxt;
      s1_du1_r <= s1_du1_nxt;
      s1_dv1_r <= s1_dv1_nxt;
      s1_du2_r <= s1_du2_nxt;
      s1_dv2_r <= s1_dv2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: all products. Numerators 0..2 are the tangent, 3..5 the
  // bitangent; each is the difference of an "a" and a "b" product.
  // --------------------------------------------------------------------------
  logic signed [33:0] s2_da_nxt, s2_db_nxt, s2_da_r, s2_db_r;
  logic signed [33:0] s2_na_nxt [6], s2_nb_nxt [6], s2_na_r [6], s2_nb_r [6];
  logic signed [33:0] s2_ca_nxt [3], s2_cb_nxt [3], s2_ca_r [3], s2_cb_r [3];

  always_comb begin
    s2_da_nxt = s1_du1_r * s1_dv2_r;
    s2_db_nxt = s1_du2_r * s1_dv1_r;
    for (int k = 0; k < 3; k++) begin
      s2_na_nxt[k]   = s1_e1_r[k] * s1_dv2_r;
      s2_nb_nxt[k]   = s1_e2_r[k] * s1_dv1_r;
      s2_na_nxt[k+3] = s1_e2_r[k] * s1_du1_r;
      s2_nb_nxt[k+3] = s1_e1_r[k] * s1_du2_r;
      s2_ca_nxt[k]   = s1_e1_r[NXT[k]] * s1_e2_r[PRV[k]];
      s2_cb_nxt[k]   = s1_e1_r[PRV[k]] * s1_e2_r[NXT[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_da_r <= s2_da_nxt;
      s2_db_r <= s2_db_nxt;
      s2_na_r <= s2_na_nxt;
      s2_nb_r <= s2_nb_nxt;
      s2_ca_r <= s2_ca_nxt;
      s2_cb_r <= s2_cb_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: determinant, numerators and cross product.
  // --------------------------------------------------------------------------
  logic signed [34:0] s3_det_nxt, s3_det_r;
  logic signed [34:0] s3_n_nxt [6], s3_n_r [6];
  logic signed [34:0] s3_c_nxt [3], s3_c_r [3];

  always_comb begin
    s3_det_nxt = s2_da_r - s2_db_r;
    for (int j = 0; j < 6; j++) begin
      s3_n_nxt[j] = s2_na_r[j] - s2_nb_r[j];
    end
    for (int k = 0; k < 3; k++) begin
      s3_c_nxt[k] = s2_ca_r[k] - s2_cb_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_det_r <= s3_det_nxt;
      s3_n_r   <= s3_n_nxt;
      s3_c_r   <= s3_c_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes, rounding offsets, the degenerate test, and the bit
  // length of the largest cross component (same as that of their OR).
  // --------------------------------------------------------------------------
  logic [34:0]     s4_absd_nxt, s4_absd_r;
  logic            s4_deg_nxt, s4_deg_r;
  logic [34:0]     n_abs [6];
  logic [TN_W-1:0] s4_num_nxt [6], s4_num_r [6];
  logic [5:0]      s4_neg_nxt, s4_neg_r;
  logic [33:0]     s4_m_nxt [3], s4_m_r [3];
  logic [2:0]      s4_cneg_nxt, s4_cneg_r;
  logic [33:0]     m_or;
  logic [5:0]      s4_len_nxt, s4_len_r;
  logic            s4_az_nxt, s4_az_r;
  logic            s4_nen_r;

  always_comb begin
    s4_absd_nxt = s3_det_r[34] ? 35'(-s3_det_r) : 35'(s3_det_r);
    s4_deg_nxt  = s4_absd_nxt <= 35'(thr_r);
    for (int j = 0; j < 6; j++) begin
      n_abs[j]      = s3_n_r[j][34] ? 35'(-s3_n_r[j]) : 35'(s3_n_r[j]);
      s4_num_nxt[j] = {n_abs[j], 15'b0} + TN_W'(s4_absd_nxt);
      s4_neg_nxt[j] = s3_n_r[j][34] ^ s3_det_r[34];
    end
    for (int k = 0; k < 3; k++) begin
      s4_m_nxt[k]    = s3_c_r[k][34] ? 34'(-s3_c_r[k]) : 34'(s3_c_r[k]);
      s4_cneg_nxt[k] = s3_c_r[k][34];
    end
    m_or       = s4_m_nxt[0] | s4_m_nxt[1] | s4_m_nxt[2];
    s4_len_nxt = '0;
    for (int b = 0; b < 34; b++) begin
      if (m_or[b]) begin
        s4_len_nxt = 6'(b + 1);
      end
    end
    s4_az_nxt = nrm_en_r && (m_or == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_absd_r <= s4_absd_nxt;
      s4_deg_r  <= s4_deg_nxt;
      s4_num_r  <= s4_num_nxt;
      s4_neg_r  <= s4_neg_nxt;
      s4_m_r    <= s4_m_nxt;
      s4_cneg_r <= s4_cneg_nxt;
      s4_len_r  <= s4_len_nxt;
      s4_az_r   <= s4_az_nxt;
      s4_nen_r  <= nrm_en_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: tangent quotient overflow check; normal components scaled so
  // the largest one lies in [2^30, 2^31).
  // --------------------------------------------------------------------------
  logic [TN_W-1:0] s5_num_r [6];
  logic [TD_W-1:0] s5_den_r;
  logic [5:0]      s5_ovf_nxt, s5_ovf_r;
  logic [5:0]      s5_neg_r;
  logic            s5_deg_r;
  logic [30:0]     s5_m_nxt [3], s5_m_r [3];
  logic [2:0]      s5_cneg_r;
  logic            s5_az_r, s5_nen_r;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      s5_ovf_nxt[j] = (TD_W + T_QW)'(s4_num_r[j]) >= {s4_absd_r, 1'b0, T_QW'(0)};
    end
    for (int k = 0; k < 3; k++) begin
      if (s4_len_r > 6'd31) begin
        s5_m_nxt[k] = 31'(s4_m_r[k] >> (s4_len_r - 6'd31));
      end else begin
        s5_m_nxt[k] = 31'(s4_m_r[k] << (6'd31 - s4_len_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_num_r  <= s4_num_r;
      s5_den_r  <= {s4_absd_r, 1'b0};
      s5_ovf_r  <= s5_ovf_nxt;
      s5_neg_r  <= s4_neg_r;
      s5_deg_r  <= s4_deg_r;
      s5_m_r    <= s5_m_nxt;
      s5_cneg_r <= s4_cneg_r;
      s5_az_r   <= s4_az_r;
      s5_nen_r  <= s4_nen_r;
    end
  end

  // --------------------------------------------------------------------------
  // Tangent dividers, one per component, followed by a delay line that lines
  // the results up with the normal path.
  // --------------------------------------------------------------------------
  logic [5:0]      tdiv_vld;
  logic [T_QW-1:0] tdiv_quo  [6];
  logic [2:0]      tdiv_side [6];

  for (genvar j = 0; j < 6; j++) begin : g_tdiv
    ttf_div #(
      .NW (TN_W),
      .DW (TD_W),
      .QW (T_QW),
      .SW (3)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld_s5_r),
      .in_num   (s5_num_r[j]),
      .in_den   (s5_den_r),
      .in_side  ({s5_deg_r, s5_neg_r[j], s5_ovf_r[j]}),
      .out_vld  (tdiv_vld[j]),
      .out_quo  (tdiv_quo[j]),
      .out_side (tdiv_side[j])
    );
  end

  tan_dly_t tan_head;
  tan_dly_t dly_r [TAN_DLY];

  always_comb begin
    tan_head.vld = &tdiv_vld;
    tan_head.deg = tdiv_side[0][2];
    for (int j = 0; j < 6; j++) begin
      tan_head.res[j].neg = tdiv_side[j][1];
      tan_head.res[j].ovf = tdiv_side[j][0];
      tan_head.res[j].quo = tdiv_quo[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAN_DLY; i++) begin
        dly_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      dly_r[0] <= tan_head;
      for (int i = 1; i < TAN_DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6 and 7: squared length of the scaled normal.
  // --------------------------------------------------------------------------
  logic [61:0] s6_sq_nxt [3], s6_sq_r [3];
  logic [30:0] s6_m_r [3];
  logic [2:0]  s6_cneg_r;
  logic        s6_az_r, s6_nen_r;
  logic [63:0] s7_sum_r;
  nrm_side_t   s7_side_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s6_sq_nxt[k] = 62'(s5_m_r[k]) * 62'(s5_m_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sq_r   <= s6_sq_nxt;
      s6_m_r    <= s5_m_r;
      s6_cneg_r <= s5_cneg_r;
      s6_az_r   <= s5_az_r;
      s6_nen_r  <= s5_nen_r;
      s7_sum_r  <= 64'(s6_sq_r[0]) + 64'(s6_sq_r[1]) + 64'(s6_sq_r[2]);
      s7_side_r.nen <= s6_nen_r;
      s7_side_r.az  <= s6_az_r;
      s7_side_r.neg <= s6_cneg_r;
      for (int k = 0; k < 3; k++) begin
        s7_side_r.mag[k] <= s6_m_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the squared length.
  // --------------------------------------------------------------------------
  logic [SQRT_RW-1:0] sq_root;
  logic [SIDE_W-1:0]  sq_side_bits;
  nrm_side_t          sq_side;

  ttf_sqrt #(
    .RW (SQRT_RW),
    .SW (SIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_s7_r),
    .in_rad   (s7_sum_r),
    .in_side  (s7_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side_bits)
  );

  assign sq_side = nrm_side_t'(sq_side_bits);

  // --------------------------------------------------------------------------
  // Normal divider prep and dividers: each component is m * 2^14 / r,
  // rounded half away from zero.
  // --------------------------------------------------------------------------
  logic [NN_W-1:0] np_num_r [3];
  logic [ND_W-1:0] np_den_r;
  nrm_side_t       np_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        np_num_r[k] <= {sq_side.mag[k], 15'b0} + NN_W'(sq_root);
      end
      np_den_r  <= {sq_root, 1'b0};
      np_side_r <= sq_side;
    end
  end

  logic [2:0]      ndiv_vld;
  logic [N_QW-1:0] ndiv_quo  [3];
  logic [2:0]      ndiv_side [3];

  for (genvar k = 0; k < 3; k++) begin : g_ndiv
    ttf_div #(
      .NW (NN_W),
      .DW (ND_W),
      .QW (N_QW),
      .SW (3)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld_np_r),
      .in_num   (np_num_r[k]),
      .in_den   (np_den_r),
      .in_side  ({np_side_r.nen, np_side_r.az, np_side_r.neg[k]}),
      .out_vld  (ndiv_vld[k]),
      .out_quo  (ndiv_quo[k]),
      .out_side (ndiv_side[k])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, clamp and pack. A degenerate UV map gives zero
  // tangents; a disabled or zero-area normal gives a zero normal.
  // --------------------------------------------------------------------------
  tan_dly_t          tail;
  logic              res_vld;
  logic [T_QW-1:0]   tval [6];
  logic [5:0]        tsat;
  logic [VEC_W-1:0]  tan_nxt, bit_nxt;
  logic [NRM_W-1:0]  nrm_nxt;
  logic              nrm_on;
  logic [VEC_W-1:0]  out_tan_r, out_bit_r;
  logic [NRM_W-1:0]  out_nrm_r;
  logic              out_deg_r, out_az_r, out_sat_r;

  assign tail    = dly_r[TAN_DLY-1];
  assign res_vld = &ndiv_vld;
  assign nrm_on  = ndiv_side[0][2] && !ndiv_side[0][1];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      tval[j] = '0;
      tsat[j] = 1'b0;
      if (!tail.deg) begin
        if (tail.res[j].neg) begin
          if (tail.res[j].ovf || tail.res[j].quo > T_MIN) begin
            tval[j] = T_MIN;
            tsat[j] = 1'b1;
          end else begin
            tval[j] = T_QW'(-tail.res[j].quo);
          end
        end else begin
          if (tail.res[j].ovf || tail.res[j].quo > T_MAX) begin
            tval[j] = T_MAX;
            tsat[j] = 1'b1;
          end else begin
            tval[j] = tail.res[j].quo;
          end
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      tan_nxt[20*k +: 20] = tval[k];
      bit_nxt[20*k +: 20] = tval[k+3];
      if (!nrm_on) begin
        nrm_nxt[16*k +: 16] = '0;
      end else if (ndiv_side[k][0]) begin
        // Widen before negating so a full-scale quotient keeps its sign.
        nrm_nxt[16*k +: 16] = -{1'b0, ndiv_quo[k]};
      end else begin
        nrm_nxt[16*k +: 16] = 16'(ndiv_quo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tan_r <= tan_nxt;
      out_bit_r <= bit_nxt;
      out_nrm_r <= nrm_nxt;
      out_deg_r <= tail.deg;
      out_az_r  <= ndiv_side[0][1];
      out_sat_r <= |tsat;
    end
  end

  assign out_tangent_vector   = out_tan_r;
  assign out_bitangent_vector = out_bit_r;
  assign out_face_normal      = out_nrm_r;
  assign out_uv_degenerate    = out_deg_r;
  assign out_area_zero        = out_az_r;
  assign out_saturated        = out_sat_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The delayed tangent results must meet the normal results in step.
  a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld == res_vld)
    else $error("tangent and normal paths out of step");

  // A degenerate UV map never reports clamped or nonzero tangents.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_uv_degenerate |->
      out_tangent_vector == '0 && out_bitangent_vector == '0 && !out_saturated)
    else $error("degenerate UV with nonzero tangent output");

  // A zero-area triangle gives a zero normal.
  a_area_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_area_zero |-> out_face_normal == '0)
    else $error("zero area with nonzero normal");

  // A held result stays valid and keeps its tangent and face normal while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tangent_vector)
      && $stable(out_face_normal))
    else $error("result changed under stall");

endmodule
